>>> src/lcdn_pkg.sv
// Shared widths, codes, wait constants and the strobe program of the LCD nibble sequencer.
`default_nettype none

package lcdn_pkg;

  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 2;
  localparam int COL_W      = 6;
  localparam int NIB_W      = 4;
  localparam int ENABLE_W   = 10;
  localparam int SETTLE_W   = 20;
  localparam int HOLD_W     = 25;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int ADDR_W     = 7;

  // DDRAM offset between the first and second display rows
  localparam int ROW_STRIDE = 64;
  localparam int COL_MAX    = 40;

  localparam logic [ENABLE_W-1:0] ENABLE_PULSE_RESET = ENABLE_W'(500);
  localparam logic [SETTLE_W-1:0] SETTLE_RESET       = SETTLE_W'(100000);

  localparam logic [HOLD_W-1:0] WAIT_POWERUP = HOLD_W'(20000000);
  localparam logic [HOLD_W-1:0] WAIT_FIRST   = HOLD_W'(5000000);
  localparam logic [HOLD_W-1:0] WAIT_SECOND  = HOLD_W'(200000);
  localparam logic [HOLD_W-1:0] WAIT_FUNCSET = HOLD_W'(50000);
  localparam logic [HOLD_W-1:0] WAIT_ENTRY   = HOLD_W'(10000000);
  localparam logic [HOLD_W-1:0] WAIT_ADDRESS = HOLD_W'(100000);
  localparam logic [HOLD_W-1:0] WAIT_CLEAR   = HOLD_W'(2000000);

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT,
    KIND_CHAR_AT,
    KIND_CHAR_HERE,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_PULSE,
    CFG_SETTLE
  } cfg_index_t;

  typedef enum logic [2:0] {
    NIB_CONST,
    NIB_ADDR_HI,
    NIB_ADDR_LO,
    NIB_CHAR_HI,
    NIB_CHAR_LO
  } nib_sel_t;

  typedef enum logic [2:0] {
    EXTRA_NONE,
    EXTRA_FIRST,
    EXTRA_SECOND,
    EXTRA_FUNCSET,
    EXTRA_ENTRY,
    EXTRA_ADDRESS,
    EXTRA_CLEAR
  } extra_t;

  typedef enum logic [1:0] {
    PH_POWERUP,
    PH_HIGH,
    PH_LOW
  } phase_kind_t;

  // One nibble strobe of the program
  typedef struct packed {
    logic             rs;
    nib_sel_t         nib_sel;
    logic [NIB_W-1:0] nib_const;
    extra_t           extra;
    logic             last;
  } step_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        load;
    phase_kind_t ph;
    step_t       step;
  } lcdn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } lcdn_status_t;

  localparam logic [STEP_W-1:0] STEP_INIT      = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_CHAR_AT   = STEP_W'(14);
  localparam logic [STEP_W-1:0] STEP_CHAR_HERE = STEP_W'(16);
  localparam logic [STEP_W-1:0] STEP_CLEAR     = STEP_W'(18);

  function automatic step_t mk_step(input logic rs, input nib_sel_t sel,
                                    input logic [NIB_W-1:0] c, input extra_t extra,
                                    input logic last);
    step_t s;
    s.rs        = rs;
    s.nib_sel   = sel;
    s.nib_const = c;
    s.extra     = extra;
    s.last      = last;
    return s;
  endfunction

  // Strobe program: initialise, char at position, char here (shares the
  // tail of char at position), clear.
  function automatic step_t step_entry(input logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:    s = mk_step(1'b0, NIB_CONST, 4'h3, EXTRA_FIRST, 1'b0);
      5'd1:    s = mk_step(1'b0, NIB_CONST, 4'h3, EXTRA_SECOND, 1'b0);
      5'd2:    s = mk_step(1'b0, NIB_CONST, 4'h3, EXTRA_NONE, 1'b0);
      5'd3:    s = mk_step(1'b0, NIB_CONST, 4'h2, EXTRA_NONE, 1'b0);
      5'd4:    s = mk_step(1'b0, NIB_CONST, 4'h2, EXTRA_NONE, 1'b0);
      5'd5:    s = mk_step(1'b0, NIB_CONST, 4'h8, EXTRA_FUNCSET, 1'b0);
      5'd6:    s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b0);
      5'd7:    s = mk_step(1'b0, NIB_CONST, 4'h8, EXTRA_NONE, 1'b0);
      5'd8:    s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b0);
      5'd9:    s = mk_step(1'b0, NIB_CONST, 4'h1, EXTRA_NONE, 1'b0);
      5'd10:   s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b0);
      5'd11:   s = mk_step(1'b0, NIB_CONST, 4'h6, EXTRA_ENTRY, 1'b0);
      5'd12:   s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b0);
      5'd13:   s = mk_step(1'b0, NIB_CONST, 4'hC, EXTRA_NONE, 1'b1);
      5'd14:   s = mk_step(1'b0, NIB_ADDR_HI, 4'h0, EXTRA_NONE, 1'b0);
      5'd15:   s = mk_step(1'b0, NIB_ADDR_LO, 4'h0, EXTRA_ADDRESS, 1'b0);
      5'd16:   s = mk_step(1'b1, NIB_CHAR_HI, 4'h0, EXTRA_NONE, 1'b0);
      5'd17:   s = mk_step(1'b1, NIB_CHAR_LO, 4'h0, EXTRA_NONE, 1'b1);
      5'd18:   s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b0);
      5'd19:   s = mk_step(1'b0, NIB_CONST, 4'h1, EXTRA_CLEAR, 1'b1);
      default: s = mk_step(1'b0, NIB_CONST, 4'h0, EXTRA_NONE, 1'b1);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/lcdn_ifs.sv
// Request and pin-phase channel interfaces of the LCD nibble sequencer.
`default_nettype none

interface lcdn_req_if;
  logic                         valid;
  logic                         ready;
  logic [lcdn_pkg::KIND_W-1:0]  kind;
  logic [lcdn_pkg::CHAR_W-1:0]  char_code;
  logic [lcdn_pkg::ROW_W-1:0]   row;
  logic [lcdn_pkg::COL_W-1:0]   column;

  modport source (output valid, kind, char_code, row, column, input ready);
  modport sink   (input valid, kind, char_code, row, column, output ready);
endinterface

interface lcdn_phase_if;
  logic                         valid;
  logic                         ready;
  logic                         reg_select;
  logic                         enable;
  logic [lcdn_pkg::NIB_W-1:0]   nibble;
  logic [lcdn_pkg::HOLD_W-1:0]  hold_ns;
  logic                         last;

  modport source (output valid, reg_select, enable, nibble, hold_ns, last, input ready);
  modport sink   (input valid, reg_select, enable, nibble, hold_ns, last, output ready);
endinterface

`default_nettype wire

>>> src/lcdn_ctrl.sv
// Sequencing state machine: walks the strobe program for one request.
`default_nettype none

module lcdn_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lcdn_pkg::KIND_W-1:0] kind,
  input  wire lcdn_pkg::lcdn_status_t      status,
  output lcdn_pkg::lcdn_cmd_t              cmd
);
  import lcdn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWERUP,
    ST_HIGH,
    ST_LOW
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  step_t             entry;
  logic              accept;

  assign entry    = step_entry(step);
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.capture = accept;
    cmd.load    = (state != ST_IDLE) && status.out_free;
    cmd.step    = entry;
    case (state)
      ST_POWERUP: cmd.ph = PH_POWERUP;
      ST_HIGH:    cmd.ph = PH_HIGH;
      ST_LOW:     cmd.ph = PH_LOW;
      default:    cmd.ph = PH_HIGH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_INIT;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind_t'(kind))
              KIND_INIT: begin
                step  <= STEP_INIT;
                state <= ST_POWERUP;
              end
              KIND_CHAR_AT: begin
                step  <= STEP_CHAR_AT;
                state <= ST_HIGH;
              end
              KIND_CHAR_HERE: begin
                step  <= STEP_CHAR_HERE;
                state <= ST_HIGH;
              end
              default: begin
                step  <= STEP_CLEAR;
                state <= ST_HIGH;
              end
            endcase
          end
        end
        ST_POWERUP: begin
          if (cmd.load) state <= ST_HIGH;
        end
        ST_HIGH: begin
          if (cmd.load) state <= ST_LOW;
        end
        ST_LOW: begin
          if (cmd.load) begin
            if (entry.last) begin
              state <= ST_IDLE;
            end else begin
              step  <= step + STEP_W'(1);
              state <= ST_HIGH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/lcdn_datapath.sv
// Timing registers, request latch, address build and registered phase output.
`default_nettype none

module lcdn_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lcdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcdn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [lcdn_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [lcdn_pkg::ROW_W-1:0]      row,
  input  wire logic [lcdn_pkg::COL_W-1:0]      column,
  input  wire lcdn_pkg::lcdn_cmd_t             cmd,
  output lcdn_pkg::lcdn_status_t               status,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 reg_select,
  output logic                                 enable,
  output logic [lcdn_pkg::NIB_W-1:0]           nibble,
  output logic [lcdn_pkg::HOLD_W-1:0]          hold_ns,
  output logic                                 last
);
  import lcdn_pkg::*;

  logic [ENABLE_W-1:0] enable_pulse;
  logic [SETTLE_W-1:0] settle;
  logic [CHAR_W-1:0]   char_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;

  logic [COL_W-1:0]    col_c;
  logic [ADDR_W-1:0]   offset;
  logic [CHAR_W-1:0]   addr_byte;
  logic [NIB_W-1:0]    nib_next;
  logic [HOLD_W-1:0]   extra_ns;
  logic [HOLD_W-1:0]   hold_next;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse <= ENABLE_PULSE_RESET;
      settle       <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE_PULSE: enable_pulse <= cfg_data[ENABLE_W-1:0];
        CFG_SETTLE:       settle       <= cfg_data[SETTLE_W-1:0];
        default:          settle       <= settle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q <= char_code;
      row_q  <= row;
      col_q  <= column;
    end
  end

  // Clamp row to 1..2 and column to 1..40, then form the set-address byte
  always_comb begin
    if (col_q == COL_W'(0))            col_c = COL_W'(1);
    else if (col_q > COL_W'(COL_MAX))  col_c = COL_W'(COL_MAX);
    else                               col_c = col_q;
    offset = ((row_q >= ROW_W'(2)) ? ADDR_W'(ROW_STRIDE) : ADDR_W'(0))
           + ADDR_W'(col_c - COL_W'(1));
    addr_byte = {1'b1, offset};
  end

  always_comb begin
    case (cmd.step.nib_sel)
      NIB_CONST:   nib_next = cmd.step.nib_const;
      NIB_ADDR_HI: nib_next = addr_byte[7:4];
      NIB_ADDR_LO: nib_next = addr_byte[3:0];
      NIB_CHAR_HI: nib_next = char_q[7:4];
      NIB_CHAR_LO: nib_next = char_q[3:0];
      default:     nib_next = cmd.step.nib_const;
    endcase
  end

  always_comb begin
    case (cmd.step.extra)
      EXTRA_NONE:    extra_ns = '0;
      EXTRA_FIRST:   extra_ns = WAIT_FIRST;
      EXTRA_SECOND:  extra_ns = WAIT_SECOND;
      EXTRA_FUNCSET: extra_ns = WAIT_FUNCSET;
      EXTRA_ENTRY:   extra_ns = WAIT_ENTRY;
      EXTRA_ADDRESS: extra_ns = WAIT_ADDRESS;
      EXTRA_CLEAR:   extra_ns = WAIT_CLEAR;
      default:       extra_ns = '0;
    endcase
    case (cmd.ph)
      PH_POWERUP: hold_next = WAIT_POWERUP;
      PH_HIGH:    hold_next = HOLD_W'(enable_pulse);
      PH_LOW:     hold_next = HOLD_W'(settle) + extra_ns;
      default:    hold_next = HOLD_W'(enable_pulse);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reg_select <= (cmd.ph == PH_POWERUP) ? 1'b0 : cmd.step.rs;
      enable     <= (cmd.ph == PH_HIGH);
      nibble     <= (cmd.ph == PH_POWERUP) ? NIB_W'(0) : nib_next;
      hold_ns    <= hold_next;
      last       <= (cmd.ph == PH_LOW) && cmd.step.last;
    end
  end

endmodule

`default_nettype wire

>>> src/char_lcd_nibble_interface_sequencer_core.sv
// Top level of the 4-bit character-LCD bus sequencer: controller plus datapath.
`default_nettype none

// Each accepted request is expanded into a run of pin phases for a 4-bit
// character LCD: RS level, enable level, the D7..D4 nibble and how long to
// hold them in ns. Bytes go out high nibble first; each nibble strobe is an
// enable-high phase (enable_pulse_ns) followed by an enable-low phase
// (settle_ns plus any extra command wait). Initialise gives 29 phases
// (power-up wait, wake-up nibbles 3,3,3,2, then function set, display off,
// clear, entry mode, display on), char-at-position 8, char-here 4 and clear 4;
// the final phase of each request carries last. The controller emits one
// phase per cycle into a single output register while the sink takes every
// transfer at once; back-pressure on the phase channel holds the sequencer
// until the pending phase is taken. A new request is taken as soon as the
// last phase of the previous one has been loaded, even while that phase
// still waits to be taken. Timing registers (index 0 enable_pulse_ns, index
// 1 settle_ns) are written through the plain write port; the user must write
// them only while the block is idle (the block itself does not enforce it),
// and they are used as written.
module char_lcd_nibble_interface_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lcdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcdn_pkg::CFG_DATA_W-1:0] cfg_data,
  lcdn_req_if.sink                             req,
  lcdn_phase_if.source                         phase
);
  import lcdn_pkg::*;

  lcdn_cmd_t    cmd;
  lcdn_status_t status;

  // Sequencer: owns the program counter and the request handshake
  lcdn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .kind     (req.kind),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: timing registers, latched request, phase output register
  lcdn_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_code  (req.char_code),
    .row        (req.row),
    .column     (req.column),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (phase.ready),
    .out_valid  (phase.valid),
    .reg_select (phase.reg_select),
    .enable     (phase.enable),
    .nibble     (phase.nibble),
    .hold_ns    (phase.hold_ns),
    .last       (phase.last)
  );

`ifndef ASSERT_OFF
  // Never overwrite a phase that the sink has not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!phase.valid || phase.ready))
    else $error("phase loaded over a pending transfer");

  // In the cycle after a request is taken the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while sequencing");

  // The closing phase of a request always leaves enable low
  a_last_enable_low: assert property (@(posedge clk) disable iff (rst)
    (phase.valid && phase.last) |-> !phase.enable)
    else $error("last phase with enable high");

  // Capture of a request and a phase load never coincide
  a_no_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !cmd.load)
    else $error("phase load while taking a request");
`endif

endmodule

`default_nettype wire
